/* hw/rtl/bmrs_pkg.sv */
// ----------------------------------------------------------------------------
// bmrs_pkg: shared types and constants
// Widths, opcodes, item structs and state encodings for the bitmap block.
// ----------------------------------------------------------------------------
package bmrs_pkg;

    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = 1024;
    localparam int MAX_RESULTS = 32;
    localparam int WB          = $clog2(WORD_BITS);
    localparam int AW          = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CAP_W       = WB + AW + 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [14:0] start_bit;
        logic [15:0] length;
        logic [15:0] limit;
    } t_in_item;

    typedef struct packed {
        logic [14:0] bit_index;
        logic        found;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        K_ACK,
        K_SET,
        K_CLEAR,
        K_SCAN
    } t_kind;

    // classified command between front and back
    typedef struct packed {
        t_kind            kind;
        logic [CAP_W-1:0] pos;
        logic [CAP_W-1:0] stop;
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEARMEM,
        S_IDLE,
        S_RANGE_RD,
        S_RANGE_WR,
        S_SCAN_RD,
        S_SCAN_EMIT,
        S_ACK
    } t_state;

endpackage

/* hw/rtl/bmrs_front.sv */
// ----------------------------------------------------------------------------
// bmrs_front: request classification
// Clamps ranges to capacity and resolves scan bounds into a command queue.
// ----------------------------------------------------------------------------
module bmrs_front import bmrs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_take
);
    localparam logic [CAP_W:0] CAP = (CAP_W+1)'(WORD_BITS * MAP_WORDS);

    t_cmd        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_cmd        w_cmd;
    logic [CAP_W:0] w_end, w_sw_end, w_lim;
    logic [CAP_W:0] w_wbase;
    logic        w_acc;

    always_comb begin
        w_end    = (CAP_W+1)'(i_item.start_bit) + (CAP_W+1)'(i_item.length);
        w_wbase  = (CAP_W+1)'(i_item.start_bit >> WB) << WB;
        w_sw_end = w_wbase + (CAP_W+1)'(WORD_BITS);
        w_lim    = (CAP_W+1)'(i_item.limit);
        w_cmd.kind = K_ACK;
        w_cmd.pos  = w_wbase[CAP_W-1:0];
        w_cmd.stop = '0;
        case (i_item.opcode)
            OP_SET, OP_CLEAR: begin
                w_cmd.kind = (i_item.opcode == OP_SET) ? K_SET : K_CLEAR;
                w_cmd.pos  = CAP_W'(i_item.start_bit);
                w_cmd.stop = CAP_W'((w_end > CAP) ? CAP : w_end);
            end
            OP_SCAN: begin
                w_cmd.kind = K_SCAN;
                w_cmd.stop = CAP_W'((w_lim < w_sw_end) ? w_lim : w_sw_end);
            end
            default: w_cmd.kind = K_ACK;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign w_acc       = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) r_wp <= ~r_wp;
            if (i_cmd_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_acc) - 2'(i_cmd_take);
        end
    end
endmodule

/* hw/rtl/bmrs_back.sv */
// ----------------------------------------------------------------------------
// bmrs_back: bitmap execution
// Holds the bitmap memory, applies ranges word by word (read, then write), walks scans.
// ----------------------------------------------------------------------------
module bmrs_back import bmrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      o_res_valid,
    output t_out_item o_res,
    input  logic      i_res_take
);
    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    t_state r_state, n_state;
    t_kind  r_kind;
    logic [CAP_W-1:0] r_pos, r_stop;
    logic [AW-1:0] r_clr;
    logic [WORD_BITS-1:0] r_hits;
    logic [CNT_W-1:0] r_nres;
    logic       r_ov;
    t_out_item  r_out;

    logic [AW-1:0] w_word;
    logic [WB-1:0] w_lo;
    logic [CAP_W-1:0] w_wbase, w_top, w_next;
    logic [WB:0] w_hi;
    logic [WORD_BITS-1:0] w_mask, w_wdata, w_low;
    logic w_we, w_rd, w_out_free, w_emit, w_anyhit, w_more;
    logic [WB-1:0] w_first;
    logic [WORD_BITS-1:0] w_rest;

    assign w_word  = r_pos[WB+AW-1:WB];
    assign w_lo    = r_pos[WB-1:0];
    assign w_wbase = {r_pos[CAP_W-1:WB], WB'(0)};
    assign w_top   = r_stop - w_wbase;
    assign w_hi    = (w_top >= CAP_W'(WORD_BITS)) ? (WB+1)'(WORD_BITS) : w_top[WB:0];
    assign w_next  = w_wbase + CAP_W'(w_hi);

    always_comb begin
        w_mask = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            w_mask[j] = (j >= int'(w_lo)) && (j < int'(w_hi));
        end
        w_wdata = (r_kind == K_SET) ? (r_rdata | w_mask) : (r_rdata & ~w_mask);
    end

    // lowest set bit of the pending hits
    always_comb begin
        w_first = '0;
        for (int j = WORD_BITS-1; j >= 0; j--) begin
            if (r_hits[j]) w_first = WB'(j);
        end
        w_low  = r_hits & (~r_hits + 1'b1);
        w_rest = r_hits & ~w_low;
    end

    assign w_out_free = !o_res_valid || i_res_take;
    assign w_anyhit   = (r_hits != '0);
    assign w_more     = (w_rest != '0) && (r_nres + 1'b1 < CNT_W'(MAX_RESULTS));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEARMEM: if (r_clr == AW'(MAP_WORDS-1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_SET, K_CLEAR: n_state = (i_cmd.pos < i_cmd.stop) ?
                                                  S_RANGE_RD : S_ACK;
                        K_SCAN:         n_state = (i_cmd.pos < i_cmd.stop) ?
                                                  S_SCAN_RD : S_ACK;
                        default:        n_state = S_ACK;
                    endcase
                end
            end
            S_RANGE_RD:  n_state = S_RANGE_WR;
            S_RANGE_WR:  n_state = (w_next < r_stop) ? S_RANGE_RD : S_ACK;
            S_SCAN_RD:   n_state = S_SCAN_EMIT;
            S_SCAN_EMIT: begin
                if (!w_anyhit) n_state = S_ACK;
                else if (w_out_free && !w_more) n_state = S_IDLE;
            end
            S_ACK:       if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
        w_we   = (r_state == S_RANGE_WR) || (r_state == S_CLEARMEM);
        w_rd   = (r_state == S_RANGE_RD) || (r_state == S_SCAN_RD);
        w_emit = 1'b0;
        case (r_state)
            S_SCAN_EMIT: w_emit = w_anyhit && w_out_free;
            S_ACK:       w_emit = w_out_free;
            default:     w_emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            if (r_state == S_CLEARMEM) r_mem[r_clr] <= '0;
            else r_mem[w_word] <= w_wdata;
        end
        if (w_rd) r_rdata <= r_mem[w_word];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_kind <= i_cmd.kind;
            r_pos  <= i_cmd.pos;
            r_stop <= i_cmd.stop;
            r_nres <= '0;
        end
        if (r_state == S_RANGE_WR) r_pos <= w_next;
        if (r_state == S_SCAN_RD) begin
            for (int j = 0; j < WORD_BITS; j++) begin
                r_hits[j] <= (CAP_W'(j) < w_top);
            end
        end else if (r_state == S_SCAN_EMIT && r_nres == '0 && !r_ov) begin
            // first cycle after the read: qualify hits with the data
            r_hits <= r_hits & r_rdata;
        end else if (r_state == S_SCAN_EMIT && w_emit) begin
            r_hits <= w_rest;
            r_nres <= r_nres + 1'b1;
        end
        if (w_emit) begin
            r_out.bit_index <= (r_state == S_ACK) ? 15'd0 :
                               15'({r_pos[CAP_W-1:WB], w_first});
            r_out.found     <= (r_state == S_SCAN_EMIT);
            r_out.last      <= (r_state == S_ACK) || !w_more;
        end
    end

    // r_ov marks that the hit mask already holds the data-qualified bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEARMEM;
            r_clr       <= '0;
            o_res_valid <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= (r_state == S_SCAN_EMIT && !r_ov) ? S_SCAN_EMIT : n_state;
            if (r_state == S_CLEARMEM) r_clr <= r_clr + 1'b1;
            if (w_emit && (r_ov || r_state == S_ACK)) o_res_valid <= 1'b1;
            else if (i_res_take) o_res_valid <= 1'b0;
            if (r_state == S_SCAN_RD) r_ov <= 1'b0;
            else if (r_state == S_SCAN_EMIT) r_ov <= 1'b1;
        end
    end

    assign o_res = r_out;
endmodule

/* hw/rtl/bitmap_range_mark_and_scan_top.sv */
// ----------------------------------------------------------------------------
// bitmap_range_mark_and_scan_top: allocation bitmap with range mark and scan
// Front classifier, two-entry command queue, back-end executor with memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-word bitmap to zero, one word per
// cycle. Up to two requests can be pushed during the sweep; they wait in
// the command queue until it ends. A set or clear request then reads and
// writes each touched word in turn and ends with an acknowledge; a scan
// reads its word, qualifies the hits with the data and reports the set bits
// lowest first. The bitmap memory is single-port with a registered read.
module bitmap_range_mark_and_scan_top import bmrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);
    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_take, w_res_valid, w_full;

    bmrs_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_item,
        .o_full(w_full), .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd),
        .i_cmd_take(w_cmd_take)
    );

    bmrs_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_take(w_cmd_take), .o_res_valid(w_res_valid), .o_res(o_item),
        .i_res_take(pop && w_res_valid)
    );

    assign full  = w_full;
    assign empty = !w_res_valid;
endmodule

/* hw/rtl/bmrs_checker.sv */
// ----------------------------------------------------------------------------
// bmrs_checker: port-level checks
// Watches the top-level queue ports for consistent result framing.
// ----------------------------------------------------------------------------
module bmrs_checker import bmrs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_item
);
    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_item.found) |-> (o_item.bit_index == 15'd0 && o_item.last))
        else $error("ack result not clean");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("result changed while waiting");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result after reset");
endmodule

bind bitmap_range_mark_and_scan_top bmrs_checker u_chk (
    .i_clk, .i_rst_n, .full, .empty, .pop, .o_item
);

/* tb/bitmap_range_mark_and_scan_top_test.sv */
// ----------------------------------------------------------------------------
// bitmap_range_mark_and_scan_top_test: self-checking bench for the bitmap
// Drives set, clear and scan requests through the queue-style ports with
// random gaps and stalls, predicts every result from a local bitmap copy
// and compares each popped result field by field in order.
// ----------------------------------------------------------------------------
module bitmap_range_mark_and_scan_top_test;
    import bmrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP        = WORD_BITS * MAP_WORDS;
    localparam int CYCLE_STOP = 3000000;
    localparam int N_RANDOM   = 440;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_item;

    bitmap_range_mark_and_scan_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_item (i_item),
        .empty  (empty),
        .pop    (pop),
        .o_item (o_item)
    );

    logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
    t_out_item            pending_results [$];
    int                   error_count;
    int                   cycle_count;
    bit                   stimulus_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Apply one request to the local bitmap and queue the results it causes.
    task automatic predict_request(input t_in_item req);
        int unsigned pos, stop, w, lo, hi, n, idx;
        t_out_item   r;
        if (req.opcode == OP_SET || req.opcode == OP_CLEAR) begin
            pos  = 32'(req.start_bit);
            stop = pos + 32'(req.length);
            if (stop > CAP) stop = CAP;
            while (pos < stop) begin
                w  = pos / WORD_BITS;
                lo = pos % WORD_BITS;
                hi = (stop - w * WORD_BITS >= WORD_BITS) ? WORD_BITS : stop - w * WORD_BITS;
                for (int j = lo; j < hi; j++) shadow_map[w][j] = (req.opcode == OP_SET);
                pos = w * WORD_BITS + hi;
            end
        end else if (req.opcode == OP_SCAN) begin
            n = 0;
            w = 32'(req.start_bit) / WORD_BITS;
            if (w < MAP_WORDS) begin
                for (int j = 0; j < WORD_BITS && n < MAX_RESULTS; j++) begin
                    idx = w * WORD_BITS + j;
                    if (idx >= 32'(req.limit)) break;
                    if (shadow_map[w][j]) begin
                        r.bit_index = idx[14:0];
                        r.found     = 1'b1;
                        r.last      = 1'b0;
                        pending_results.push_back(r);
                        n++;
                    end
                end
            end
            if (n > 0) begin
                pending_results[$].last = 1'b1;
                return;
            end
        end
        r = '{bit_index: '0, found: 1'b0, last: 1'b1};
        pending_results.push_back(r);
    endtask

    // Directed table: opcode, start, length, limit, plus an optional typed
    // expectation for the last result of the row.
    typedef struct {
        t_in_item  req;
        bit        has_fixed;
        t_out_item fixed;
    } t_row;

    t_row directed_rows [$];

    task automatic add_row(input logic [1:0] op, input int unsigned s, input int unsigned l,
                           input int unsigned lim, input bit fixed, input t_out_item f);
        t_row row;
        row.req       = '{opcode: op, start_bit: s[14:0], length: l[15:0], limit: lim[15:0]};
        row.has_fixed = fixed;
        row.fixed     = f;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input t_in_item req);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            push   <= 1'b0;
            i_item <= t_in_item'($urandom());
            repeat (gap) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_request(req);
        @(negedge i_clk);
    endtask

    function automatic t_in_item random_request();
        t_in_item    r;
        int unsigned sel;
        sel         = $urandom_range(0, 99);
        r.opcode    = 2'($urandom_range(0, 2));
        // keep most activity inside a few words so scans find bits
        r.start_bit = $urandom_range(0, 9) < 7 ? 15'($urandom_range(0, 255)) :
                                                 15'($urandom());
        r.length    = sel < 70 ? 16'($urandom_range(0, 70)) :
                      sel < 95 ? 16'($urandom_range(0, 400)) :
                                 16'($urandom_range(0, 32768));
        r.limit     = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'd32768;
        if (sel == 99) r.opcode = 2'd3;
        return r;
    endfunction

    initial begin
        t_out_item ack, none;
        ack  = '{bit_index: '0, found: 1'b0, last: 1'b1};
        none = ack;
        error_count   = 0;
        stimulus_done = 1'b0;
        i_rst_n = 1'b0;
        push    = 1'b0;
        i_item  = '0;
        foreach (shadow_map[k]) shadow_map[k] = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(OP_SCAN,  0,     0,     32768, 1, none);   // empty after reset
        add_row(OP_SET,   0,     0,     0,     1, ack);    // zero length
        add_row(OP_SET,   3,     1,     0,     1, ack);    // single bit
        add_row(OP_SCAN,  5,     0,     32768, 1, '{bit_index: 15'd3, found: 1'b1, last: 1'b1});
        add_row(OP_SET,   30,    40,    0,     1, ack);    // leading, whole, trailing
        add_row(OP_SCAN,  40,    0,     32768, 0, ack);
        add_row(OP_SCAN,  0,     0,     31,    0, ack);
        add_row(OP_SCAN,  33,    0,     32,    1, none);   // limit at word base
        add_row(OP_SCAN,  33,    0,     0,     1, none);
        add_row(OP_CLEAR, 31,    2,     0,     1, ack);
        add_row(OP_SCAN,  0,     0,     32768, 0, ack);
        add_row(OP_SET,   32700, 65535, 0,     1, ack);    // clamped at capacity
        add_row(OP_SCAN,  32767, 0,     65535, 0, ack);
        add_row(OP_SCAN,  32767, 0,     32767, 0, ack);
        add_row(OP_SET,   32767, 32768, 0,     1, ack);
        add_row(OP_SET,   64,    32,    0,     1, ack);    // full word, 32 hits
        add_row(OP_SCAN,  64,    0,     65535, 0, ack);
        add_row(2'd3,     100,   5,     5,     1, ack);    // unused opcode
        add_row(OP_SCAN,  100,   0,     32768, 0, ack);
        add_row(OP_CLEAR, 0,     32768, 0,     1, ack);    // wipe everything
        add_row(OP_SCAN,  32767, 0,     32768, 1, none);
        add_row(OP_SET,   0,     32768, 0,     1, ack);
        add_row(OP_SCAN,  12345, 0,     32768, 0, ack);
        add_row(OP_CLEAR, 16384, 16384, 0,     1, ack);

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].req);
            if (directed_rows[k].has_fixed && pending_results.size() > 0) begin
                if (pending_results[$] !== directed_rows[k].fixed)
                    report_mismatch($sformatf("row %0d prediction disagrees with table", k));
            end
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            send_request(random_request());
            // hold off once until the result queue drains
            if (k == N_RANDOM / 2) begin
                push <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge i_clk);
            end
        end
        push <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Result side: random stalls, compare each popped result with the oldest.
    initial begin
        int        stall;
        t_out_item exp_r;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                exp_r = pending_results.pop_front();
                if (o_item.bit_index !== exp_r.bit_index)
                    report_mismatch($sformatf("bit_index %0d, want %0d",
                                              o_item.bit_index, exp_r.bit_index));
                if (o_item.found !== exp_r.found)
                    report_mismatch($sformatf("found %0b, want %0b", o_item.found, exp_r.found));
                if (o_item.last !== exp_r.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_item.last, exp_r.last));
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_STOP) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        wait (pending_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
